// ----- rtl/core/dstf_pkg.sv -----
// Shared types and constants for the decimal string to fixed-point converter.
package dstf_pkg;

    typedef logic [63:0] t_word;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_TOO_LONG     = 2'd1,
        ST_SECOND_POINT = 2'd2,
        ST_BAD_CHAR     = 2'd3
    } t_status;

    // Character codes
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    localparam logic [5:0] MAX_LENGTH_RESET = 6'd20;
    localparam logic [5:0] POS_MAX          = 6'd63;
    localparam logic [4:0] FRAC_DIGIT_CAP   = 5'd18;

    // Parser state seen by the sequencer when a string completes
    typedef struct packed {
        t_word   int_acc;
        t_word   frac_acc;
        t_word   frac_den;
        logic    neg;
        t_status err;
        logic    sat;
    } t_parse;

endpackage

// ----- rtl/core/dstf_parser.sv -----
// Per-character parser: sign, integer part, fraction numerator and its power of ten.
module dstf_parser import dstf_pkg::*; #(
    parameter int FRAC_BITS    = 24,
    parameter int LENGTH_LIMIT = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic       i_clear,
    input  logic [7:0] i_char_code,
    input  logic [5:0] i_max_length,
    output t_parse     o_state
);

    localparam t_word      IntLimit = (64'd1 << (63 - FRAC_BITS)) - 64'd1;
    localparam logic [6:0] LenLimit = 7'(LENGTH_LIMIT);

    logic [5:0] r_pos,   n_pos;
    logic       r_point, n_point;
    logic       r_neg,   n_neg;
    logic       r_sat,   n_sat;
    t_word      r_int,   n_int;
    t_word      r_frac,  n_frac;
    t_word      r_den,   n_den;
    logic [4:0] r_digits, n_digits;
    t_status    r_err,   n_err;

    logic [6:0] limit;
    logic [7:0] digit_raw;
    t_word      digit;
    t_word      int_next;
    t_word      frac_next;
    t_word      den_next;
    logic       is_digit;
    t_status    err_now;

    // Length limit in force and the times-ten-plus-digit updates
    always_comb begin
        limit     = ({1'b0, i_max_length} < LenLimit) ? {1'b0, i_max_length} : LenLimit;
        digit_raw = i_char_code - CH_ZERO;
        digit     = 64'(digit_raw[3:0]);
        is_digit  = (i_char_code >= CH_ZERO) && (i_char_code <= CH_NINE);
        int_next  = (r_int << 3) + (r_int << 1) + digit;
        frac_next = (r_frac << 3) + (r_frac << 1) + digit;
        den_next  = (r_den << 3) + (r_den << 1);
        err_now   = ({1'b0, r_pos} >= limit) ? ST_TOO_LONG : r_err;
    end

    // Next parser state
    always_comb begin
        n_pos    = r_pos;
        n_point  = r_point;
        n_neg    = r_neg;
        n_sat    = r_sat;
        n_int    = r_int;
        n_frac   = r_frac;
        n_den    = r_den;
        n_digits = r_digits;
        n_err    = r_err;
        if (i_clear) begin
            n_pos    = '0;
            n_point  = 1'b0;
            n_neg    = 1'b0;
            n_sat    = 1'b0;
            n_int    = '0;
            n_frac   = '0;
            n_den    = 64'd1;
            n_digits = '0;
            n_err    = ST_OK;
        end else if (i_step) begin
            n_err = err_now;
            if (r_pos != POS_MAX) begin
                n_pos = r_pos + 6'd1;
            end
            if (err_now == ST_OK) begin
                if (is_digit) begin
                    if (!r_point) begin
                        // integer part, saturating at the format limit
                        if (r_sat) begin
                            n_int = IntLimit;
                        end else if (int_next > IntLimit) begin
                            n_int = IntLimit;
                            n_sat = 1'b1;
                        end else begin
                            n_int = int_next;
                        end
                    end else if (r_digits < FRAC_DIGIT_CAP) begin
                        n_frac   = frac_next;
                        n_den    = den_next;
                        n_digits = r_digits + 5'd1;
                    end
                end else if (i_char_code == CH_POINT) begin
                    if (r_point) begin
                        n_err = ST_SECOND_POINT;
                    end else begin
                        n_point = 1'b1;
                    end
                end else if ((i_char_code == CH_PLUS || i_char_code == CH_MINUS)
                             && r_pos == 6'd0) begin
                    n_neg = (i_char_code == CH_MINUS);
                end else begin
                    n_err = ST_BAD_CHAR;
                end
            end
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_point  <= 1'b0;
            r_neg    <= 1'b0;
            r_sat    <= 1'b0;
            r_int    <= '0;
            r_frac   <= '0;
            r_den    <= 64'd1;
            r_digits <= '0;
            r_err    <= ST_OK;
        end else begin
            r_pos    <= n_pos;
            r_point  <= n_point;
            r_neg    <= n_neg;
            r_sat    <= n_sat;
            r_int    <= n_int;
            r_frac   <= n_frac;
            r_den    <= n_den;
            r_digits <= n_digits;
            r_err    <= n_err;
        end
    end

    assign o_state.int_acc  = r_int;
    assign o_state.frac_acc = r_frac;
    assign o_state.frac_den = r_den;
    assign o_state.neg      = r_neg;
    assign o_state.err      = r_err;
    assign o_state.sat      = r_sat;

endmodule

// ----- rtl/core/dstf_divider.sv -----
// Restoring fraction divider: one compare-and-subtract step per cycle.
module dstf_divider import dstf_pkg::*; #(
    parameter int FRAC_BITS = 24
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  t_word                i_num,
    input  t_word                i_den,
    output logic                 o_busy,
    output logic [FRAC_BITS-1:0] o_quot
);

    localparam int CntW = $clog2(FRAC_BITS + 1);

    logic                 r_busy;
    logic [CntW-1:0]      r_count;
    t_word                r_rem;
    t_word                r_den;
    logic [FRAC_BITS-1:0] r_quot;

    t_word rem_shift;
    t_word rem_sub;
    logic  fits;

    // Shared step: double the remainder and try the denominator
    always_comb begin
        rem_shift = r_rem << 1;
        fits      = (rem_shift >= r_den);
        rem_sub   = rem_shift - r_den;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_count <= '0;
        end else if (i_start) begin
            r_busy  <= 1'b1;
            r_count <= CntW'(FRAC_BITS);
        end else if (r_busy) begin
            r_count <= r_count - CntW'(1);
            if (r_count == CntW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_num;
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= fits ? rem_sub : rem_shift;
            r_quot <= {r_quot[FRAC_BITS-2:0], fits};
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;

    // remainder stays below the denominator throughout
    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_rem < r_den) else $error("divider remainder not reduced");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_busy) else $error("divider did not start");

    a_last_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !i_start && r_count == CntW'(1)) |=> !r_busy)
        else $error("divider overran its step count");

endmodule

// ----- rtl/core/decimal_string_to_fixed.sv -----
// Top level: ASCII decimal string to signed fixed-point converter with sequencer.
// Non-final characters: one request per cycle while idle, parsed at acceptance.
// Final character: the sequencer passes through S_PREP, S_DIV and S_DONE, waiting in S_DIV
// on the bit-per-cycle fraction divider; the result is registered once the output is free,
// and input stalls until the result is loaded.
// Synchronous active-low reset clears the parser and sets max_length to 20.
module decimal_string_to_fixed import dstf_pkg::*; #(
    parameter int FRAC_BITS    = 24,
    parameter int LENGTH_LIMIT = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [7:0]         i_char_code,
    input  logic               i_final_char,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [63:0] o_fixed_value,
    output logic [1:0]         o_status,
    output logic               o_int_overflow,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [5:0]         i_cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PREP,
        S_DIV,
        S_DONE
    } t_state;

    t_state     r_state;
    logic [5:0] r_max_length;
    logic       r_out_valid;
    t_word      r_fixed_value;
    t_status    r_status;
    logic       r_int_overflow;

    t_parse                parse;
    logic                  in_accept;
    logic                  out_free;
    logic                  load_result;
    logic                  div_busy;
    logic [FRAC_BITS-1:0]  div_quot;
    t_word                 mag;
    t_word                 value;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign load_result = (r_state == S_DONE) && out_free;

    dstf_parser #(
        .FRAC_BITS    (FRAC_BITS),
        .LENGTH_LIMIT (LENGTH_LIMIT)
    ) u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (in_accept),
        .i_clear      (load_result),
        .i_char_code  (i_char_code),
        .i_max_length (r_max_length),
        .o_state      (parse)
    );

    dstf_divider #(
        .FRAC_BITS (FRAC_BITS)
    ) u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_PREP),
        .i_num   (parse.frac_acc),
        .i_den   (parse.frac_den),
        .o_busy  (div_busy),
        .o_quot  (div_quot)
    );

    // Assemble magnitude and apply sign
    always_comb begin
        mag   = (parse.int_acc << FRAC_BITS) | 64'(div_quot);
        value = parse.neg ? (64'd0 - mag) : mag;
    end

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_length <= MAX_LENGTH_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_max_length <= i_cfg_data;
        end
    end

    // Sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_accept && i_final_char) begin
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (!div_busy) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
        if (load_result) begin
            if (parse.err != ST_OK) begin
                r_fixed_value  <= '0;
                r_int_overflow <= 1'b0;
            end else begin
                r_fixed_value  <= value;
                r_int_overflow <= parse.sat;
            end
            r_status <= parse.err;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_fixed_value  = r_fixed_value;
    assign o_status       = r_status;
    assign o_int_overflow = r_int_overflow;

    a_final_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_final_char) |=> r_state == S_PREP)
        else $error("final character did not start conversion");

    a_div_to_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && !div_busy) |=> r_state == S_DONE)
        else $error("sequencer missed divider completion");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status != ST_OK) |-> (r_fixed_value == '0 && !r_int_overflow))
        else $error("error result carries a value");

endmodule
